[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps

package mexp_pkg;

  // Word width of every field on the channels
  localparam int unsigned DATA_WIDTH = 32;

  // The modular multiplier consumes one multiplier bit per cycle
  localparam int unsigned MUL_STEPS = DATA_WIDTH;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  // Operand selection when a modular multiply is started
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULT
  } mul_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_START_SQ,
    ST_SQUARE,
    ST_SQ_DONE,
    ST_MULT,
    ST_MUL_DONE,
    ST_FINISH
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;       // capture base and exponent
    logic    start;      // start a modular multiply
    mul_op_e op;         // operands for the multiply being started
    logic    step;       // run one multiplier bit
    logic    dest_base;  // final product goes to base instead of acc
    logic    acc_one;    // force acc to 1 (zero exponent)
    logic    exp_shift;  // advance to next exponent bit
    logic    res_load;   // load the output register from acc
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic exp_zero;
    logic exp_bit;
    logic exp_last;
    logic mul_last;
  } dp_status_t;

endpackage

[rtl/mexp_in_if.sv]
`timescale 1ns / 1ps

interface mexp_in_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] base_value;
  logic [DATA_WIDTH-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

[rtl/mexp_out_if.sv]
`timescale 1ns / 1ps

interface mexp_out_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

[rtl/mexp_cfg_if.sv]
`timescale 1ns / 1ps

interface mexp_cfg_if import mexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

[rtl/mexp_datapath.sv]
`timescale 1ns / 1ps

module mexp_datapath import mexp_pkg::*; #(
  parameter int unsigned MOD_WIDTH = 32,
  parameter int unsigned EXP_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DATA_WIDTH-1:0] cfg_modulus_i,
  input  logic [DATA_WIDTH-1:0] base_value_i,
  input  logic [DATA_WIDTH-1:0] exponent_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [DATA_WIDTH-1:0] power_result_o
);

  localparam int unsigned EXP_CNT_W = $clog2(EXP_WIDTH + 1);
  localparam int unsigned SUM_W     = MOD_WIDTH + 2;

  logic [MOD_WIDTH-1:0]  mod_q, mod_d;
  logic [MOD_WIDTH-1:0]  acc_q, acc_d;
  logic [MOD_WIDTH-1:0]  base_q, base_d;
  logic [MOD_WIDTH-1:0]  mcand_q, mcand_d;
  logic [MOD_WIDTH-1:0]  r_q, r_d;
  logic [DATA_WIDTH-1:0] mplier_q, mplier_d;
  logic [EXP_WIDTH-1:0]  exp_q, exp_d;
  logic [EXP_CNT_W-1:0]  exp_cnt_q, exp_cnt_d;
  logic [MUL_CNT_W-1:0]  step_q, step_d;
  logic [DATA_WIDTH-1:0] result_q, result_d;

  logic [MOD_WIDTH-1:0]            cfg_mod;
  logic [MOD_WIDTH-1:0]            one_mod;
  logic [EXP_WIDTH+DATA_WIDTH-1:0] exp_ext;
  logic [MOD_WIDTH-1:0]            addend;
  logic [SUM_W-1:0]                sum, mod1, mod2, dif1, dif2;
  logic [MOD_WIDTH-1:0]            r_next;
  logic                            mul_done;

  // Modulus write: zero is out of range and stands for one
  assign cfg_mod = cfg_modulus_i[MOD_WIDTH-1:0];
  assign mod_d   = (cfg_mod == '0) ? MOD_WIDTH'(1) : cfg_mod;

  // 1 mod m
  assign one_mod = (mod_q == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  // Exponent fitted to EXP_WIDTH (zero-extend or truncate)
  assign exp_ext = {{EXP_WIDTH{1'b0}}, exponent_i};

  // One bit of interleaved multiply: r = 2r + bit*mcand, then reduce (result < 3m)
  assign addend = mplier_q[DATA_WIDTH-1] ? mcand_q : '0;
  assign sum    = {1'b0, r_q, 1'b0} + {2'b00, addend};
  assign mod1   = {2'b00, mod_q};
  assign mod2   = {1'b0, mod_q, 1'b0};
  assign dif1   = sum - mod1;
  assign dif2   = sum - mod2;

  always_comb begin
    if (sum >= mod2) begin
      r_next = dif2[MOD_WIDTH-1:0];
    end else if (sum >= mod1) begin
      r_next = dif1[MOD_WIDTH-1:0];
    end else begin
      r_next = sum[MOD_WIDTH-1:0];
    end
  end

  assign mul_done = cmd_i.step && (step_q == '0);

  // Next-state logic for the datapath registers
  always_comb begin
    acc_d     = acc_q;
    base_d    = base_q;
    mcand_d   = mcand_q;
    r_d       = r_q;
    mplier_d  = mplier_q;
    exp_d     = exp_q;
    exp_cnt_d = exp_cnt_q;
    step_d    = step_q;
    result_d  = result_q;

    if (cmd_i.load) begin
      mplier_d  = base_value_i;
      exp_d     = exp_ext[EXP_WIDTH-1:0];
      exp_cnt_d = EXP_CNT_W'(EXP_WIDTH);
    end

    if (cmd_i.acc_one) begin
      acc_d = MOD_WIDTH'(1);
    end

    if (cmd_i.start) begin
      r_d    = '0;
      step_d = MUL_CNT_W'(MUL_STEPS - 1);
      case (cmd_i.op)
        OP_REDUCE: begin
          // base mod m computed as base * (1 mod m); acc starts at 1 mod m
          mcand_d = one_mod;
          acc_d   = one_mod;
        end
        OP_SQUARE: begin
          mplier_d = DATA_WIDTH'(acc_q);
          mcand_d  = acc_q;
        end
        OP_MULT: begin
          mplier_d = DATA_WIDTH'(acc_q);
          mcand_d  = base_q;
        end
        default: begin
          mcand_d = mcand_q;
        end
      endcase
    end

    if (cmd_i.step) begin
      r_d      = r_next;
      mplier_d = {mplier_q[DATA_WIDTH-2:0], 1'b0};
      step_d   = step_q - MUL_CNT_W'(1);
    end

    // Final product written straight to its destination
    if (mul_done) begin
      if (cmd_i.dest_base) begin
        base_d = r_next;
      end else begin
        acc_d = r_next;
      end
    end

    if (cmd_i.exp_shift) begin
      exp_d     = {exp_q[EXP_WIDTH-2:0], 1'b0};
      exp_cnt_d = exp_cnt_q - EXP_CNT_W'(1);
    end

    if (cmd_i.res_load) begin
      result_d = DATA_WIDTH'(acc_q);
    end
  end

  // Control-like registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= MOD_WIDTH'(1);
      step_q    <= '0;
      exp_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= mod_d;
      end
      step_q    <= step_d;
      exp_cnt_q <= exp_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    base_q   <= base_d;
    mcand_q  <= mcand_d;
    r_q      <= r_d;
    mplier_q <= mplier_d;
    exp_q    <= exp_d;
    result_q <= result_d;
  end

  // Status
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_bit  = exp_q[EXP_WIDTH-1];
  assign status_o.exp_last = (exp_cnt_q == EXP_CNT_W'(1));
  assign status_o.mul_last = (step_q == '0);

  assign power_result_o = result_q;

endmodule

[rtl/mexp_ctrl.sv]
`timescale 1ns / 1ps

module mexp_ctrl import mexp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = OP_SQUARE;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.exp_zero) begin
          cmd_o.acc_one = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_REDUCE;
          state_d     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.step      = 1'b1;
        cmd_o.dest_base = 1'b1;
        if (status_i.mul_last) begin
          state_d = ST_START_SQ;
        end
      end
      ST_START_SQ: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_SQUARE;
        state_d     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.step = 1'b1;
        if (status_i.mul_last) begin
          state_d = ST_SQ_DONE;
        end
      end
      ST_SQ_DONE: begin
        if (status_i.exp_bit) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_MULT;
          state_d     = ST_MULT;
        end else begin
          cmd_o.exp_shift = 1'b1;
          if (status_i.exp_last) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OP_SQUARE;
            state_d     = ST_SQUARE;
          end
        end
      end
      ST_MULT: begin
        cmd_o.step = 1'b1;
        if (status_i.mul_last) begin
          state_d = ST_MUL_DONE;
        end
      end
      ST_MUL_DONE: begin
        cmd_o.exp_shift = 1'b1;
        if (status_i.exp_last) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_SQUARE;
          state_d     = ST_SQUARE;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output word valid
  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps

// Modular exponentiation: power_result = base_value ^ exponent mod modulus.
// Channels: in_i takes a word of base_value and exponent, out_o returns one
// power_result word per input word, cfg_i writes the modulus (always ready).
// The user must write the modulus only while the block is idle; the block
// itself does not enforce this. Zero acts as one. An exponent of zero
// returns 1 without reduction. Otherwise the base is first reduced, then
// each of the EXP_WIDTH exponent bits costs a square plus a multiply when
// the bit is set. The run time is set by the bit-serial modular
// multiplier, which consumes one multiplier bit per cycle.
// One word is processed at a time; in_i is ready again once the result is
// in the output register, so a new word can start while out_o is stalled.
// If the receiver stalls, the next finished result waits inside the block.
// Reset returns the controller to idle, clears out_o valid and sets the
// modulus to 1.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned MOD_WIDTH = 32,
  parameter int unsigned EXP_WIDTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  mexp_cfg_if.sink  cfg_i,
  mexp_in_if.sink   in_i,
  mexp_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_datapath #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_modulus_i  (cfg_i.modulus),
    .base_value_i   (in_i.base_value),
    .exponent_i     (in_i.exponent),
    .cmd_i          (cmd),
    .status_o       (status),
    .power_result_o (out_o.power_result)
  );

endmodule

[rtl/mexp_checker.sv]
`timescale 1ns / 1ps

module mexp_checker import mexp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] power_result_i
);

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_i;

  // A stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(power_result_i))
    else $error("output word changed while stalled");

  // One word at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input accepted while busy");

  // No result can appear before the controller has passed its check and finish states
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("result produced too early");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .power_result_i (out_o.power_result)
);
